@@ sv/lsss_pkg.sv @@
package lsss_pkg;

  // Default number of stack entries.
  localparam int unsigned STACK_DEPTH_DEFAULT = 16;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OPCODE_W = 2;

  // Input beat: opcode in the lowest bits, then the value, padded to bytes.
  localparam int unsigned IN_W = ((OPCODE_W + VALUE_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_SORT   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

endpackage

@@ sv/lsss_out_buf.sv @@
module lsss_out_buf #(
  parameter int unsigned CNT_W = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  lsss_pkg::status_t     load_status,
  input  logic                  load_found,
  input  logic [CNT_W-1:0]      load_count,
  output logic                  free,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from the lowest bit up: status, found, entry_count, zero padding.
  output logic [((CNT_W + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import lsss_pkg::*;

  localparam int unsigned OUT_W = ((CNT_W + 3 + 7) / 8) * 8;

  logic             valid;
  status_t          status;
  logic             found;
  logic [CNT_W-1:0] count;

  // The slot can take a new result when it is empty or being drained now.
  assign free = !valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= load_status;
      found  <= load_found;
      count  <= load_count;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = OUT_W'({count, found, status});

endmodule

@@ sv/lifo_stack_search_sort_unit.sv @@
// Channel   Role    Beat contents (lowest bit first)
// s_axis    input   opcode[1:0], value[33:2] (signed), zero pad to 40 bits
// m_axis    output  status[1:0], found[2], entry_count, zero pad to whole bytes
//
// One command is taken at a time; the input is ready whenever the controller is idle,
// even while the previous result still waits in the output register.
// Push and pop go straight to the result; search and sort step through the entries
// one read at a time, set by the single read port of the entry memory feeding
// one comparator.
// Reset (rst, synchronous, active high) empties the stack; the memory itself
// is not cleared since only entries below the count are ever read.
// A stalled output holds the finished result and keeps the controller waiting.
module lifo_stack_search_sort_unit #(
  parameter int unsigned STACK_DEPTH = lsss_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // Fields from the lowest bit up: opcode, value, zero padding.
  input  logic [lsss_pkg::IN_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // Fields from the lowest bit up: status, found, entry_count, zero padding.
  output logic [(($clog2(STACK_DEPTH + 1) + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import lsss_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_LOADU  = 6'b000100,
    S_CMP    = 6'b001000,
    S_WBACK  = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state;

  // Entry memory: index 0 is the bottom of the stack.
  logic signed [VALUE_W-1:0] mem [STACK_DEPTH];
  logic signed [VALUE_W-1:0] rdata;
  logic [AW-1:0]             raddr;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wdata;

  logic [CW-1:0]             count;
  logic signed [VALUE_W-1:0] key;
  logic [CW-1:0]             idx;
  logic                      rd_vld;
  logic                      found;
  status_t                   status;
  logic signed [VALUE_W-1:0] up;
  logic [AW-1:0]             upos;
  logic [AW-1:0]             lpos;

  opcode_t                   opcode;
  logic signed [VALUE_W-1:0] value;
  logic                      accept;
  logic                      full;
  logic                      ob_free;
  logic                      ob_load;
  logic                      swap;

  assign opcode = opcode_t'(s_axis_tdata[OPCODE_W-1:0]);
  assign value  = s_axis_tdata[OPCODE_W +: VALUE_W];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count == CW'(STACK_DEPTH));
  assign swap          = (up > rdata);
  assign ob_load       = (state == S_RESP) && ob_free;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Memory port control. The sort keeps the upper entry in a register and
  // writes only the lower entry on a swap, so read and write never meet at
  // the same address in one cycle.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = up;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && (opcode == OP_PUSH) && (value != '0) && !full) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wdata = value;
        end
        raddr = AW'(count - CW'(1));
      end
      S_SEARCH: begin
        raddr = idx[AW-1:0];
      end
      S_LOADU: begin
        raddr = upos - AW'(1);
      end
      S_CMP: begin
        we    = swap;
        waddr = lpos;
        raddr = lpos - AW'(1);
      end
      S_WBACK: begin
        we    = 1'b1;
        waddr = upos;
        raddr = upos - AW'(1);
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            key    <= value;
            found  <= 1'b0;
            status <= ST_OK;
            state  <= S_RESP;
            case (opcode)
              OP_PUSH: begin
                if (value == '0) begin
                  status <= ST_ZERO;
                end else if (full) begin
                  status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              OP_POP: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  count <= count - CW'(1);
                end
              end
              OP_SEARCH: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  idx    <= '0;
                  rd_vld <= 1'b0;
                  state  <= S_SEARCH;
                end
              end
              OP_SORT: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else if (count != CW'(1)) begin
                  // The read of the top entry was issued this cycle.
                  upos  <= AW'(count - CW'(1));
                  state <= S_LOADU;
                end
              end
              default: begin
                status <= ST_OK;
              end
            endcase
          end
        end
        S_SEARCH: begin
          // Reads stream one per cycle; each compare checks the registered data of the previous read.
          rd_vld <= (idx != count);
          if (idx != count) begin
            idx <= idx + CW'(1);
          end
          if (rd_vld && (rdata == key)) begin
            found <= 1'b1;
          end
          if ((idx == count) && !rd_vld) begin
            state <= S_RESP;
          end
        end
        S_LOADU: begin
          up    <= rdata;
          lpos  <= upos - AW'(1);
          state <= S_CMP;
        end
        S_CMP: begin
          if (swap) begin
            up <= rdata;
          end
          if (lpos != '0) begin
            lpos <= lpos - AW'(1);
          end else begin
            state <= S_WBACK;
          end
        end
        S_WBACK: begin
          if (upos == AW'(1)) begin
            state <= S_RESP;
          end else begin
            upos  <= upos - AW'(1);
            state <= S_LOADU;
          end
        end
        S_RESP: begin
          if (ob_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  lsss_out_buf #(
    .CNT_W (CW)
  ) u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .load          (ob_load),
    .load_status   (status),
    .load_found    (found),
    .load_count    (count),
    .free          (ob_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ verif/lifo_stack_search_sort_unit_tb.sv @@
module lifo_stack_search_sort_unit_tb;
  import lsss_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEFAULT;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W = ((COUNT_W + 3 + 7) / 8) * 8;
  localparam int unsigned PAD_W = IN_W - OPCODE_W - VALUE_W;
  localparam int unsigned RANDOM_ITEMS = 1900;
  // With fewer than this many commands left, both sides stop idling.
  localparam int unsigned CALM_TAIL = 250;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    opcode_t            op;
    logic signed [31:0] value;
    bit                 drain;  // hold this command back until no result is owed
  } command_t;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [COUNT_W-1:0]   entry_count;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // Fields from the lowest bit up: opcode, value, zero padding.
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // Fields from the lowest bit up: status, found, entry_count.
  logic [OUT_W-1:0]    m_axis_tdata;

  command_t            queued_commands[$];
  outcome_t            awaited_outcomes[$];
  command_t            live_cmd;
  logic signed [31:0]  pushed_pool[$];

  // Shadow copy of the stack: index 0 is the bottom.
  logic signed [31:0]  shadow[DEPTH];
  int unsigned         held = 0;

  int unsigned         error_count = 0;
  int unsigned         gap_left = 0;
  int unsigned         stall_left = 0;
  longint unsigned     cycles = 0;

  lifo_stack_search_sort_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void log_fault(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // Applies one command to the shadow stack and returns the result it owes.
  function automatic outcome_t apply_command(command_t c);
    outcome_t           r;
    logic signed [31:0] swap;
    r.status = ST_OK;
    r.found  = 1'b0;
    case (c.op)
      OP_PUSH: begin
        if (c.value == 0) r.status = ST_ZERO;
        else if (held >= DEPTH) r.status = ST_FULL;
        else begin
          shadow[held] = c.value;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) r.status = ST_EMPTY;
        else held--;
      end
      OP_SEARCH: begin
        if (held == 0) r.status = ST_EMPTY;
        else begin
          for (int k = 0; k < held; k++)
            if (shadow[k] == c.value) r.found = 1'b1;
        end
      end
      default: begin
        // Exchange sort from the top down: each position keeps the smallest
        // value of itself and everything below it. Equal values stay put.
        if (held == 0) r.status = ST_EMPTY;
        else begin
          for (int top = held - 1; top > 0; top--) begin
            for (int k = top - 1; k >= 0; k--) begin
              if (shadow[top] > shadow[k]) begin
                swap        = shadow[top];
                shadow[top] = shadow[k];
                shadow[k]   = swap;
              end
            end
          end
        end
      end
    endcase
    r.entry_count = held[COUNT_W-1:0];
    return r;
  endfunction

  task automatic add_cmd(opcode_t op, logic signed [31:0] v, bit drain = 1'b0);
    command_t c;
    c.op    = op;
    c.value = v;
    c.drain = drain;
    queued_commands.push_back(c);
    if (op == OP_PUSH && v != 0) begin
      pushed_pool.push_back(v);
      if (pushed_pool.size() > 32) void'(pushed_pool.pop_front());
    end
  endtask

  // Mix of zero, extremes, small values that repeat, earlier pushes and full
  // random words.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sd0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      2, 3, 4: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
      5, 6: begin
        if (pushed_pool.size() > 0)
          return pushed_pool[$urandom_range(0, pushed_pool.size() - 1)];
        return $signed($urandom());
      end
      default: return $signed($urandom());
    endcase
  endfunction

  // Sender: presents queued commands and predicts each one as it is accepted.
  always @(posedge clk) begin
    command_t nxt;
    bit       take;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      held = 0;
    end else begin
      take = s_axis_tvalid && s_axis_tready;
      if (take) begin
        awaited_outcomes.push_back(apply_command(live_cmd));
        if (queued_commands.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 13);
      end
      if (take || !s_axis_tvalid) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (queued_commands.size() > 0 &&
                     !(queued_commands[0].drain && awaited_outcomes.size() > 0)) begin
          nxt = queued_commands.pop_front();
          live_cmd = nxt;
          s_axis_tdata  <= {{PAD_W{1'b0}}, nxt.value, nxt.op};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat against the oldest prediction and
  // stalls in random bursts.
  always @(posedge clk) begin
    outcome_t want;
    status_t  got_status;
    logic     got_found;
    logic [COUNT_W-1:0] got_count;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = status_t'(m_axis_tdata[1:0]);
        got_found  = m_axis_tdata[2];
        got_count  = m_axis_tdata[3 +: COUNT_W];
        if (awaited_outcomes.size() == 0) begin
          log_fault($sformatf("unexpected result beat: %h", m_axis_tdata));
        end else begin
          want = awaited_outcomes.pop_front();
          if (got_status !== want.status || got_found !== want.found ||
              got_count !== want.entry_count)
            log_fault($sformatf(
              "mismatch: status %0d/%0d found %0d/%0d count %0d/%0d (expected/actual)",
              want.status, got_status, want.found, got_found,
              want.entry_count, got_count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (queued_commands.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned issued;
    int unsigned n;
    int unsigned pick;
    bit          first;

    // Directed: every command on an empty stack, extremes, duplicates,
    // searches that hit and miss, a search for zero, and a sort.
    add_cmd(OP_PUSH, 32'sd0);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_SEARCH, 32'sd5);
    add_cmd(OP_SORT, 32'sd0);
    add_cmd(OP_PUSH, 32'sh8000_0000);
    add_cmd(OP_PUSH, 32'sh7FFF_FFFF);
    add_cmd(OP_PUSH, -32'sd1);
    add_cmd(OP_PUSH, 32'sd7);
    add_cmd(OP_PUSH, 32'sd7);
    add_cmd(OP_PUSH, 32'sd1);
    add_cmd(OP_PUSH, 32'sd0);
    add_cmd(OP_SEARCH, 32'sh7FFF_FFFF);
    add_cmd(OP_SEARCH, 32'sh8000_0000);
    add_cmd(OP_SEARCH, 32'sd0);
    add_cmd(OP_SEARCH, 32'sd1234);
    add_cmd(OP_SORT, 32'sh5555_5555);
    add_cmd(OP_SORT, 32'shAAAA_AAAA);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_SEARCH, 32'sh8000_0000);
    add_cmd(OP_POP, 32'sd0);

    // Random segments: fill runs that hit the full stack (and zero pushes on
    // it), drain runs that empty it, and mixed traffic with searches that
    // mostly look for values that were pushed.
    issued = 0;
    first  = 1'b1;
    while (issued < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 1) begin
        n = $urandom_range(12, 20);
        for (int k = 0; k < n; k++)
          add_cmd(OP_PUSH, ($urandom_range(0, 15) == 0) ? 32'sd0 : pick_value(),
                  first && k == 0);
      end else if (pick == 2) begin
        n = $urandom_range(4, 18);
        for (int k = 0; k < n; k++)
          add_cmd(OP_POP, $signed($urandom()), first && k == 0);
      end else begin
        n = $urandom_range(10, 40);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: add_cmd(OP_PUSH, pick_value(), k == 0 && first);
            8, 9, 10, 11:           add_cmd(OP_POP, $signed($urandom()), k == 0 && first);
            12, 13, 14, 15, 16:     add_cmd(OP_SEARCH, pick_value(), k == 0 && first);
            default:                add_cmd(OP_SORT, $signed($urandom()), k == 0 && first);
          endcase
        end
      end
      issued += n;
      // Now and then the next segment waits for the block to go quiet.
      first = ($urandom_range(0, 30) == 0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (queued_commands.size() > 0 || s_axis_tvalid || awaited_outcomes.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (awaited_outcomes.size() > 0)
      log_fault($sformatf("%0d results never arrived", awaited_outcomes.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
